// ===== hdl/pvp_pkg.sv =====
// Package for the perspective vertex projector.
// Holds beat structs, register codes, pipeline constants and saturation helpers.
// No dependencies.
`default_nettype none
package pvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS         = 17;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X   = 3'd0,
    CFG_CAMERA_Y   = 3'd1,
    CFG_CAMERA_Z   = 3'd2,
    CFG_SCALE_X    = 3'd3,
    CFG_SCALE_Y    = 3'd4,
    CFG_HALF_WIDTH = 3'd5
  } cfg_idx_t;

  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_POINT = 1'b1;
  localparam logic [3:0] COEF_LAST = 4'd8;

  localparam logic signed [15:0] PIX_MAX = 16'sh7fff;
  localparam logic signed [15:0] PIX_MIN = 16'sh8000;

  typedef struct packed {
    logic               kind;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } pvp_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               divide_fault;
  } pvp_out_t;

  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [12:0]        half_width;
  } pvp_cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [46:0] num_x;
    logic signed [46:0] num_y;
    logic signed [31:0] w;
    logic               xneg;
    logic               yneg;
  } pvp_num_t;

  typedef struct packed {
    logic [31:0]      r;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] q;
    logic [31:0]      d;
    logic             neg;
    logic             ovf;
    logic             zero;
    logic             sneg;
  } pvp_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pvp_xform.sv =====
// Camera offset, view rotation and row reduction: three pipeline stages.
// Holds the view rotation coefficients. Depends on pvp_pkg.
`default_nettype none
module pvp_xform #(
  parameter int FRAC_BITS = pvp_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_vld,
  input  pvp_pkg::pvp_in_t     in_beat,
  input  pvp_pkg::pvp_cfg_t    cfg,
  output logic                 out_vld,
  output logic signed [31:0]   c0,
  output logic signed [31:0]   c1,
  output logic signed [31:0]   c2
);
  import pvp_pkg::*;

  logic               v1_r, kind1_r;
  logic [3:0]         idx1_r;
  logic signed [31:0] coef1_r;
  logic signed [31:0] t1_r [3];
  logic signed [31:0] rot_r [9];
  logic               v2_r;
  logic signed [63:0] prod2_r [3][3];
  logic               v3_r;
  logic signed [31:0] c3_r [3];
  logic signed [31:0] t_nxt [3];
  logic signed [31:0] c_nxt [3];

  always_comb begin
    t_nxt[0] = sat32(66'(in_beat.point_x) + 66'(cfg.camera_x));
    t_nxt[1] = sat32(66'(in_beat.point_y) + 66'(cfg.camera_y));
    t_nxt[2] = sat32(66'(in_beat.point_z) + 66'(cfg.camera_z));
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = sat32(66'(prod2_r[i][0] >>> FRAC_BITS) + 66'(prod2_r[i][1] >>> FRAC_BITS)
                     + 66'(prod2_r[i][2] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < 9; k++) rot_r[k] <= '0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r && (kind1_r == KIND_POINT);
      v3_r <= v2_r;
      if (v1_r && kind1_r == KIND_COEF && idx1_r <= COEF_LAST) begin
        rot_r[idx1_r] <= coef1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_beat.kind;
      idx1_r  <= in_beat.coef_index;
      coef1_r <= in_beat.coef_value;
      for (int j = 0; j < 3; j++) t1_r[j] <= t_nxt[j];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod2_r[i][j] <= rot_r[3*i+j] * t1_r[j];
        c3_r[i] <= c_nxt[i];
      end
    end
  end

  assign out_vld = v3_r;
  assign c0 = c3_r[0];
  assign c1 = c3_r[1];
  assign c2 = c3_r[2];

endmodule
`default_nettype wire

// ===== hdl/pvp_scale.sv =====
// Projection scaling and pixel numerator: four pipeline stages.
// Forms (s + w) * half_width for both axes. Depends on pvp_pkg.
`default_nettype none
module pvp_scale #(
  parameter int FRAC_BITS = pvp_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_vld,
  input  wire signed [31:0]   c0,
  input  wire signed [31:0]   c1,
  input  wire signed [31:0]   c2,
  input  pvp_pkg::pvp_cfg_t   cfg,
  output pvp_pkg::pvp_num_t   num
);
  import pvp_pkg::*;

  logic               v4_r, v5_r, v6_r, v7_r;
  logic signed [63:0] xp4_r, yp4_r;
  logic signed [31:0] w4_r, w5_r, w6_r, w7_r;
  logic signed [31:0] xs5_r, ys5_r;
  logic signed [32:0] sx6_r, sy6_r;
  logic               xneg6_r, yneg6_r, xneg7_r, yneg7_r;
  logic signed [46:0] nx7_r, ny7_r;
  logic signed [13:0] hw_s;

  assign hw_s = $signed({1'b0, cfg.half_width});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_vld;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp4_r   <= c0 * cfg.scale_x;
      yp4_r   <= c1 * cfg.scale_y;
      w4_r    <= c2;
      xs5_r   <= sat32(66'(xp4_r >>> FRAC_BITS));
      ys5_r   <= sat32(66'(yp4_r >>> FRAC_BITS));
      w5_r    <= w4_r;
      sx6_r   <= 33'(xs5_r) + 33'(w5_r);
      sy6_r   <= 33'(ys5_r) + 33'(w5_r);
      xneg6_r <= xs5_r[31];
      yneg6_r <= ys5_r[31];
      w6_r    <= w5_r;
      nx7_r   <= 47'(sx6_r) * 47'(hw_s);
      ny7_r   <= 47'(sy6_r) * 47'(hw_s);
      xneg7_r <= xneg6_r;
      yneg7_r <= yneg6_r;
      w7_r    <= w6_r;
    end
  end

  always_comb begin
    num.valid = v7_r;
    num.num_x = nx7_r;
    num.num_y = ny7_r;
    num.w     = w7_r;
    num.xneg  = xneg7_r;
    num.yneg  = yneg7_r;
  end

endmodule
`default_nettype wire

// ===== hdl/pvp_divider.sv =====
// Pipelined restoring divider for both pixel axes, one quotient bit per stage.
// Ends in the output register with saturation. Depends on pvp_pkg.
`default_nettype none
module pvp_divider (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  pvp_pkg::pvp_num_t   num,
  output logic                out_vld,
  output pvp_pkg::pvp_out_t   out_beat
);
  import pvp_pkg::*;

  logic      vld_r [QBITS+1];
  pvp_lane_t lx_r [QBITS+1];
  pvp_lane_t ly_r [QBITS+1];
  pvp_lane_t lx_nxt [QBITS+1];
  pvp_lane_t ly_nxt [QBITS+1];
  logic      ov_r;
  pvp_out_t  ob_r;

  function automatic pvp_lane_t setup(input logic signed [46:0] n,
                                      input logic signed [31:0] w, input logic sneg);
    pvp_lane_t  l;
    logic [46:0] mn;
    logic [31:0] md;
    mn = n[46] ? 47'(-n) : 47'(n);
    md = w[31] ? 32'(-w) : 32'(w);
    l.r    = 32'(mn[46:QBITS]);
    l.lo   = mn[QBITS-1:0];
    l.q    = '0;
    l.d    = md;
    l.neg  = n[46] ^ w[31];
    l.ovf  = {2'b00, mn} >= {md, {QBITS{1'b0}}};
    l.zero = (w == '0);
    l.sneg = sneg;
    return l;
  endfunction

  function automatic pvp_lane_t step(input pvp_lane_t l);
    pvp_lane_t  o;
    logic [32:0] cur;
    logic        ge;
    o   = l;
    cur = {l.r, l.lo[QBITS-1]};
    ge  = cur >= {1'b0, l.d};
    o.r  = ge ? 32'(cur - {1'b0, l.d}) : cur[31:0];
    o.lo = {l.lo[QBITS-2:0], 1'b0};
    o.q  = {l.q[QBITS-2:0], ge};
    return o;
  endfunction

  function automatic logic signed [15:0] pixel(input pvp_lane_t l);
    if (l.zero) return l.sneg ? PIX_MIN : PIX_MAX;
    if (l.neg) begin
      if (l.ovf || l.q > QBITS'(32768)) return PIX_MIN;
      return 16'(-$signed({1'b0, l.q}));
    end
    if (l.ovf || l.q > QBITS'(32767)) return PIX_MAX;
    return 16'(l.q);
  endfunction

  always_comb begin
    lx_nxt[0] = setup(num.num_x, num.w, num.xneg);
    ly_nxt[0] = setup(num.num_y, num.w, num.yneg);
    for (int s = 1; s <= QBITS; s++) begin
      lx_nxt[s] = step(lx_r[s-1]);
      ly_nxt[s] = step(ly_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QBITS; s++) vld_r[s] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= num.valid;
      for (int s = 1; s <= QBITS; s++) vld_r[s] <= vld_r[s-1];
      ov_r <= vld_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= QBITS; s++) begin
        lx_r[s] <= lx_nxt[s];
        ly_r[s] <= ly_nxt[s];
      end
      ob_r.screen_x     <= pixel(lx_r[QBITS]);
      ob_r.screen_y     <= pixel(ly_r[QBITS]);
      ob_r.divide_fault <= lx_r[QBITS].zero;
    end
  end

  assign out_vld  = ov_r;
  assign out_beat = ob_r;

endmodule
`default_nettype wire

// ===== hdl/perspective_vertex_projector.sv =====
// Top level of the perspective vertex projector: configuration registers,
// stall control and the xform, scale and divider pipelines. Depends on pvp_pkg.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    pvp_in_t  (coefficient write or point)
//   out      out  out_valid / out_ready  pvp_out_t (one beat per point)
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// One beat enters per cycle while the output is not held; a point passes seven arithmetic
// stages, the divider setup stage, 17 one-bit stages and the output register.
// Coefficient beats update the rotation from the registered beat of the first xform stage.
// A held output stalls every stage at once; in_ready falls with it.
// Synchronous active-low reset empties the pipeline and loads register defaults.
`default_nettype none
module perspective_vertex_projector #(
  parameter int FRAC_BITS = pvp_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  pvp_pkg::pvp_in_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output pvp_pkg::pvp_out_t                 out_data,
  input  wire                               cfg_we,
  input  wire [pvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [pvp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pvp_pkg::*;

  pvp_cfg_t           cfg_r;
  logic               en;
  logic               xf_vld;
  logic signed [31:0] c0, c1, c2;
  pvp_num_t           num;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_x   <= 32'sd0;
      cfg_r.camera_y   <= 32'sd0;
      cfg_r.camera_z   <= 32'sd327680;
      cfg_r.scale_x    <= 32'sd65536;
      cfg_r.scale_y    <= 32'sd65536;
      cfg_r.half_width <= 13'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_X:   cfg_r.camera_x   <= cfg_data;
        CFG_CAMERA_Y:   cfg_r.camera_y   <= cfg_data;
        CFG_CAMERA_Z:   cfg_r.camera_z   <= cfg_data;
        CFG_SCALE_X:    cfg_r.scale_x    <= cfg_data;
        CFG_SCALE_Y:    cfg_r.scale_y    <= cfg_data;
        CFG_HALF_WIDTH: cfg_r.half_width <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  pvp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid && in_ready),
    .in_beat(in_data), .cfg(cfg_r), .out_vld(xf_vld), .c0(c0), .c1(c1), .c2(c2)
  );

  pvp_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(xf_vld),
    .c0(c0), .c1(c1), .c2(c2), .cfg(cfg_r), .num(num)
  );

  pvp_divider u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num),
    .out_vld(out_valid), .out_beat(out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output hold");
  a_fault_rails: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_fault) |->
      ((out_data.screen_x == PIX_MAX || out_data.screen_x == PIX_MIN) &&
       (out_data.screen_y == PIX_MAX || out_data.screen_y == PIX_MIN)))
    else $error("fault beat not saturated");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for perspective_vertex_projector: random bursty beats,
// random output stalls, an in-order pixel scoreboard. Depends on pvp_pkg and the RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pvp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  class pixel_scoreboard;
    longint cam[3];
    longint scale_x, scale_y, half_w;
    longint rot[9];
    pvp_out_t pending_pixels[$];
    int errors;
    int points, faults, coef_writes;

    function new();
      cam[0] = 0; cam[1] = 0; cam[2] = 327680;
      scale_x = 65536; scale_y = 65536; half_w = 500;
      foreach (rot[i]) rot[i] = 0;
      errors = 0; points = 0; faults = 0; coef_writes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_CAMERA_X:   cam[0] = longint'(signed'(d));
        CFG_CAMERA_Y:   cam[1] = longint'(signed'(d));
        CFG_CAMERA_Z:   cam[2] = longint'(signed'(d));
        CFG_SCALE_X:    scale_x = longint'(signed'(d));
        CFG_SCALE_Y:    scale_y = longint'(signed'(d));
        CFG_HALF_WIDTH: half_w = longint'(d[12:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [15:0] to_pixel(longint s, longint w);
      longint pix;
      if (w == 0) pix = (s >= 0) ? 32767 : -32768;
      else begin
        pix = ((s + w) * half_w) / w;
        if (pix > 32767) pix = 32767;
        if (pix < -32768) pix = -32768;
      end
      return pix[15:0];
    endfunction

    function void note_input(pvp_in_t b);
      longint t[3], c[3];
      longint acc, xs, ys;
      pvp_out_t r;
      if (b.kind == KIND_COEF) begin
        if (b.coef_index <= COEF_LAST) begin
          rot[b.coef_index] = longint'(b.coef_value);
          coef_writes++;
        end
        return;
      end
      t[0] = clamp32(longint'(b.point_x) + cam[0]);
      t[1] = clamp32(longint'(b.point_y) + cam[1]);
      t[2] = clamp32(longint'(b.point_z) + cam[2]);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += (rot[i*3+j] * t[j]) >>> FRAC_BITS_DEF;
        c[i] = clamp32(acc);
      end
      xs = clamp32((c[0] * scale_x) >>> FRAC_BITS_DEF);
      ys = clamp32((c[1] * scale_y) >>> FRAC_BITS_DEF);
      r.screen_x = to_pixel(xs, c[2]);
      r.screen_y = to_pixel(ys, c[2]);
      r.divide_fault = (c[2] == 0);
      points++;
      if (r.divide_fault) faults++;
      pending_pixels.push_back(r);
    endfunction

    function void check(pvp_out_t got);
      pvp_out_t exp_r;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output beat %h", got);
        errors++;
        return;
      end
      exp_r = pending_pixels.pop_front();
      if (got.screen_x !== exp_r.screen_x) begin
        $error("screen_x expected %0d got %0d", exp_r.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== exp_r.screen_y) begin
        $error("screen_y expected %0d got %0d", exp_r.screen_y, got.screen_y);
        errors++;
      end
      if (got.divide_fault !== exp_r.divide_fault) begin
        $error("divide_fault expected %0b got %0b", exp_r.divide_fault, got.divide_fault);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pvp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pvp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int idle_cycles = 0;
  int beats_in = 0;
  bit long_hold_done = 0;

  perspective_vertex_projector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) sb.check(out_data);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d pixels outstanding", sb.pending_pixels.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: segments of always-ready, random and mostly-stalled, one long hold
  initial begin
    int seg, mode, cyc;
    cyc = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      seg = $urandom_range(5, 120);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        cyc++;
        if (!long_hold_done && cyc > 300) begin
          out_ready <= 1'b0;
          repeat (400) @(posedge clk);
          long_hold_done = 1;
          out_ready <= 1'b1;
        end else begin
          case (mode)
            0, 1: out_ready <= 1'b1;
            2: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'h0;
      default: return $urandom_range(0, 20 << 16) - (10 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h0;
      default: return $urandom_range(0, 4 << 16) - (2 << 16);
    endcase
  endfunction

  task automatic send(pvp_in_t b);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_coef(logic [3:0] idx, logic [31:0] v);
    pvp_in_t b;
    b = '0;
    b.kind = KIND_COEF;
    b.coef_index = idx;
    b.coef_value = v;
    b.point_x = $urandom;
    send(b);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pvp_in_t b;
    b.kind = KIND_POINT;
    b.coef_index = 4'($urandom);
    b.coef_value = $urandom;
    b.point_x = x;
    b.point_y = y;
    b.point_z = z;
    send(b);
  endtask

  task automatic idle_wait();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_stream(int n);
    int sent, burst, gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < n; k++) begin
        if ($urandom_range(0, 99) < 12) send_coef($urandom_range(0, 12) == 0 ?
            4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8)), rand_coef());
        else send_point(rand_q(), rand_q(), rand_q());
        sent++;
      end
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= pvp_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              5'($urandom)});
        repeat (gap) @(posedge clk);
      end
    end
    idle_wait();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity view, ignored indices, field extremes
    for (int i = 0; i <= 8; i++)
      send_coef(4'(i), (i % 4 == 0) ? 32'h0001_0000 : 32'h0);
    send_coef(4'd9, 32'h7fff_ffff);
    send_coef(4'd15, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0001_0000, 32'hffff_0000);
    send_point(32'h0002_0000, 32'hfffe_0000, 32'hfffb_0000);
    // zero depth: positive, negative and zero coordinates
    send_point(32'h0003_0000, 32'hfffd_0000, 32'hfffb_0000);
    send_point(32'hfff0_0000, 32'h0, 32'hfffb_0000);
    send_coef(4'd8, 32'h0);
    send_point(32'h0004_0000, 32'hfffc_0000, 32'h0001_0000);
    send_coef(4'd8, 32'h0001_0000);
    send_coef(4'd0, 32'h7fff_ffff);
    send_coef(4'd1, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    idle_wait();
    random_stream(330);

    cfg_write(CFG_CAMERA_X, 32'h0001_8000);
    cfg_write(CFG_CAMERA_Y, 32'hfffe_0000);
    cfg_write(CFG_CAMERA_Z, 32'h000a_0000);
    cfg_write(CFG_SCALE_X, 32'h0001_4000);
    cfg_write(CFG_SCALE_Y, 32'h0000_c000);
    cfg_write(CFG_HALF_WIDTH, 32'd320);
    cfg_done();
    random_stream(350);

    cfg_write(CFG_CAMERA_X, 32'h7fff_ffff);
    cfg_write(CFG_CAMERA_Y, 32'h8000_0000);
    cfg_write(CFG_CAMERA_Z, 32'h8000_0000);
    cfg_write(CFG_SCALE_X, 32'h7fff_ffff);
    cfg_write(CFG_SCALE_Y, 32'h8000_0000);
    cfg_write(CFG_HALF_WIDTH, 32'hffff_ffff);
    cfg_done();
    random_stream(250);

    cfg_write(CFG_CAMERA_X, 32'h0);
    cfg_write(CFG_CAMERA_Y, 32'h0);
    cfg_write(CFG_CAMERA_Z, 32'h0005_0000);
    cfg_write(CFG_SCALE_X, 32'hffff_0000);
    cfg_write(CFG_HALF_WIDTH, 32'd0);
    cfg_write(CFG_SPARE_LO, 32'h1234_5678);
    cfg_write(CFG_SPARE_HI, 32'hffff_ffff);
    cfg_done();
    random_stream(250);

    cfg_write(CFG_SCALE_Y, 32'h0);
    cfg_write(CFG_HALF_WIDTH, 32'd1);
    cfg_done();
    random_stream(250);

    cfg_write(CFG_CAMERA_X, rand_q());
    cfg_write(CFG_CAMERA_Y, rand_q());
    cfg_write(CFG_CAMERA_Z, 32'h0008_0000);
    cfg_write(CFG_SCALE_X, 32'h0001_0000);
    cfg_write(CFG_SCALE_Y, 32'h0001_0000);
    cfg_write(CFG_HALF_WIDTH, 32'd4096);
    cfg_done();
    random_stream(330);

    $display("run: %0d beats in, %0d points (%0d zero-depth), %0d coefficient writes",
             beats_in, sb.points, sb.faults, sb.coef_writes);
    $display("six configurations incl. extremes, long output hold %0s",
             long_hold_done ? "applied" : "not reached");
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
